// ===== hw/rtl/ffc_pkg.sv =====
// Shared types and constants for the floor/ceiling texel caster.
// Used by the controller, the datapath and the top level.
`default_nettype none

package ffc_pkg;

  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 5;
  localparam int NUM_REGS   = 6;
  localparam int DIVIDEND_W = 64;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_CAM_POS_X   = 3'd0;
  localparam logic [2:0] REG_CAM_POS_Y   = 3'd1;
  localparam logic [2:0] REG_VIEW_DIR_X  = 3'd2;
  localparam logic [2:0] REG_VIEW_DIR_Y  = 3'd3;
  localparam logic [2:0] REG_CAM_PLANE_X = 3'd4;
  localparam logic [2:0] REG_CAM_PLANE_Y = 3'd5;

  localparam logic signed [DATA_W-1:0] RST_CAM_POS_X   = 32'sd0;
  localparam logic signed [DATA_W-1:0] RST_CAM_POS_Y   = 32'sd0;
  localparam logic signed [DATA_W-1:0] RST_VIEW_DIR_X  = 32'sd65536;
  localparam logic signed [DATA_W-1:0] RST_VIEW_DIR_Y  = 32'sd0;
  localparam logic signed [DATA_W-1:0] RST_CAM_PLANE_X = 32'sd0;
  localparam logic signed [DATA_W-1:0] RST_CAM_PLANE_Y = 32'sd43254;

  typedef struct packed {
    logic signed [DATA_W-1:0] cam_pos_x;
    logic signed [DATA_W-1:0] cam_pos_y;
    logic signed [DATA_W-1:0] view_dir_x;
    logic signed [DATA_W-1:0] view_dir_y;
    logic signed [DATA_W-1:0] cam_plane_x;
    logic signed [DATA_W-1:0] cam_plane_y;
  } cfg_t;

  // second multiplier operand
  typedef enum logic [1:0] {
    MSEL_PLANE_X,
    MSEL_PLANE_Y,
    MSEL_DIFF_X,
    MSEL_DIFF_Y
  } msel_t;

  typedef struct packed {
    logic  latch_item;
    logic  emit_live;
    logic  emit_latched;
    logic  div_start;
    logic  div_sel_d;
    logic  cap_d;
    logic  mul_en;
    msel_t mul_sel;
    logic  cap_step_x;
    logic  cap_step_y;
    logic  cap_world_x;
    logic  cap_world_y;
  } dp_cmd_t;

  typedef struct packed {
    logic col_zero;
    logic div_done;
  } dp_sts_t;

  typedef struct packed {
    logic        [9:0]  out_column;
    logic        [8:0]  floor_row;
    logic        [7:0]  ceil_row;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic        [5:0]  texel_x;
    logic        [5:0]  texel_y;
    logic               last_in_row;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ffc_if.sv =====
// Valid/ready channel interfaces: pixel items in, texel results out.
// Standalone; widths follow the fixed field widths of the block.
`default_nettype none

interface ffc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] row_offset;
  logic [9:0] column;

  modport source (output valid, row_offset, column, input ready);
  modport sink   (input valid, row_offset, column, output ready);
endinterface

interface ffc_result_if;
  logic               valid;
  logic               ready;
  logic        [9:0]  out_column;
  logic        [8:0]  floor_row;
  logic        [7:0]  ceil_row;
  logic signed [15:0] cell_x;
  logic signed [15:0] cell_y;
  logic        [5:0]  texel_x;
  logic        [5:0]  texel_y;
  logic               last_in_row;

  modport source (output valid, out_column, floor_row, ceil_row, cell_x, cell_y,
                  texel_x, texel_y, last_in_row, input ready);
  modport sink   (input valid, out_column, floor_row, ceil_row, cell_x, cell_y,
                  texel_x, texel_y, last_in_row, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ffc_div.sv =====
// Dividers for row setup: a bit-serial restoring divider for the row distance
// and a constant divider by the screen width. No package dependencies.
`default_nettype none

module ffc_div #(
  parameter int DVD_W = 64,
  parameter int DVS_W = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] acc;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial    = {rem, acc[DVD_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
        acc  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= fits ? DVS_W'(trial - {1'b0, dvs}) : DVS_W'(trial);
        acc <= {acc[DVD_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// Unsigned division by a constant, 16 dividend bits at a time: the digit
// comes from a reciprocal multiply, the remainder from a multiply-subtract.
module ffc_cdiv #(
  parameter int DVD_W   = 64,
  parameter int DIVISOR = 640
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int DIG_W = 16;
  localparam int NDIG  = DVD_W / DIG_W;
  localparam int REM_W = $clog2(DIVISOR);
  localparam int X_W   = DIG_W + REM_W;
  localparam int XP_W  = X_W + 1;
  localparam int SHIFT = X_W + REM_W;
  localparam int M_W   = X_W + 2;
  localparam int PW    = X_W + M_W;
  localparam int CNT_W = $clog2(NDIG + 1);

  // ceil(2^SHIFT / DIVISOR): exact for any partial dividend below DIVISOR * 2^DIG_W
  localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1))
                               / longint'(DIVISOR);
  localparam logic [M_W-1:0]  RECIP = M_W'(RECIP_L);
  localparam logic [XP_W-1:0] DVS_C = XP_W'(DIVISOR);

  logic [DVD_W-1:0] acc;
  logic [REM_W-1:0] rem;
  logic [DIG_W-1:0] qd;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             phase_b;

  logic [X_W-1:0]   x;
  logic [PW-1:0]    prod;
  logic [XP_W-1:0]  qw;
  logic [XP_W-1:0]  rem_full;

  assign x        = {rem, acc[DVD_W-1 -: DIG_W]};
  assign prod     = PW'(x) * PW'(RECIP);
  assign qw       = XP_W'(qd) * DVS_C;
  assign rem_full = XP_W'(x) - qw;
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
      phase_b <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        phase_b <= 1'b0;
        cnt     <= CNT_W'(NDIG);
        acc     <= dividend;
        rem     <= '0;
      end else if (busy) begin
        phase_b <= !phase_b;
        if (!phase_b) begin
          qd <= prod[SHIFT +: DIG_W];
        end else begin
          rem <= rem_full[REM_W-1:0];
          acc <= {acc[DVD_W-DIG_W-1:0], qd};
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ffc_datapath.sv =====
// Datapath: row setup arithmetic (dividers, multiplier, saturation), world
// position state and the registered result payload. Uses ffc_pkg, ffc_div and ffc_cdiv.
`default_nettype none

module ffc_datapath #(
  parameter int SCREEN_W  = 640,
  parameter int SCREEN_H  = 480,
  parameter int TEXTURE_W = 64,
  parameter int TEXTURE_H = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ffc_pkg::cfg_t    cfg,
  input  wire ffc_pkg::dp_cmd_t cmd,
  output ffc_pkg::dp_sts_t      sts,
  input  wire logic [7:0]       row_offset,
  input  wire logic [9:0]       column,
  output ffc_pkg::res_t         res
);
  import ffc_pkg::*;

  localparam int HALF   = SCREEN_H / 2;
  localparam int ROW_W  = ($clog2(SCREEN_H + 1) > 9) ? $clog2(SCREEN_H + 1) : 9;
  localparam int COL_W  = ($clog2(SCREEN_W + 1) > 10) ? $clog2(SCREEN_W + 1) : 10;
  localparam int SZ_MAX = (TEXTURE_W > TEXTURE_H) ? TEXTURE_W : TEXTURE_H;
  localparam int SZ_W   = $clog2(SZ_MAX + 1) + 1;
  localparam int TP_W   = FRAC_BITS + 1 + SZ_W;

  localparam logic [DIVIDEND_W-1:0] NUM  = DIVIDEND_W'(HALF) << FRAC_BITS;
  localparam logic signed [SZ_W-1:0] TW_S = SZ_W'(TEXTURE_W);
  localparam logic signed [SZ_W-1:0] TH_S = SZ_W'(TEXTURE_H);
  localparam logic [TP_W-1:0] TW_M = TP_W'(TEXTURE_W - 1);
  localparam logic [TP_W-1:0] TH_M = TP_W'(TEXTURE_H - 1);
  localparam logic signed [66:0] SAT_HI = 67'sd2147483647;
  localparam logic signed [66:0] SAT_LO = -67'sd2147483648;

  function automatic logic [31:0] sat32(input logic signed [66:0] v);
    if (v > SAT_HI) return 32'h7FFF_FFFF;
    if (v < SAT_LO) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [7:0] clamp_p(input logic [7:0] r);
    logic [ROW_W-1:0] re;
    re = ROW_W'(r);
    if (r == 8'd0) return 8'd1;
    if (re > ROW_W'(HALF)) return 8'(HALF);
    return r;
  endfunction

  // integer part toward zero
  function automatic logic [15:0] cell_of(input logic signed [31:0] w);
    logic signed [31:0] whole;
    whole = w >>> FRAC_BITS;
    if (w[31] && (w[FRAC_BITS-1:0] != '0)) whole = whole + 32'sd1;
    return whole[15:0];
  endfunction

  // signed fraction (w minus its truncated part) scaled by size, toward zero
  function automatic logic [5:0] texel_of(input logic signed [31:0] w,
                                          input logic signed [SZ_W-1:0] size,
                                          input logic [TP_W-1:0] mask);
    logic signed [FRAC_BITS:0] frac;
    logic signed [TP_W-1:0]    tp;
    logic signed [TP_W-1:0]    q;
    frac = {w[31] && (w[FRAC_BITS-1:0] != '0), w[FRAC_BITS-1:0]};
    tp   = frac * size;
    q    = tp >>> FRAC_BITS;
    if (tp[TP_W-1] && (tp[FRAC_BITS-1:0] != '0)) q = q + TP_W'(1);
    return 6'(q & mask);
  endfunction

  logic        [7:0]  p_q;
  logic        [9:0]  col_q;
  logic signed [31:0] row_distance;
  logic signed [31:0] step_x;
  logic signed [31:0] step_y;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [65:0] prod_q;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic        [65:0] prod_mag;
  logic               d_done;
  logic               s_done;
  logic [DIVIDEND_W-1:0] d_quo;
  logic [DIVIDEND_W-1:0] s_quo;
  logic signed [64:0] quo_s;
  logic signed [64:0] step_sh;
  logic signed [65:0] prod_sh;

  logic        [7:0]       p_src;
  logic        [9:0]       col_src;
  logic        [ROW_W-1:0] pe;
  logic        [ROW_W-1:0] floor_w;
  logic        [ROW_W-1:0] ceil_w;
  res_t                    res_next;

  assign sts.col_zero = column == 10'd0;
  assign sts.div_done = d_done || s_done;

  // multiplier operands: distance times 2*plane or (dir - plane)
  assign mul_a = signed'({1'b0, row_distance});
  always_comb begin
    case (cmd.mul_sel)
      MSEL_PLANE_X: mul_b = signed'({cfg.cam_plane_x, 1'b0});
      MSEL_PLANE_Y: mul_b = signed'({cfg.cam_plane_y, 1'b0});
      MSEL_DIFF_X:  mul_b = 33'(cfg.view_dir_x) - 33'(cfg.cam_plane_x);
      MSEL_DIFF_Y:  mul_b = 33'(cfg.view_dir_y) - 33'(cfg.cam_plane_y);
      default:      mul_b = '0;
    endcase
  end

  // step division runs on the magnitude, sign restored after
  assign prod_mag = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
  assign quo_s    = prod_q[65] ? -signed'({1'b0, s_quo}) : signed'({1'b0, s_quo});
  assign step_sh  = quo_s >>> FRAC_BITS;
  assign prod_sh  = prod_q >>> FRAC_BITS;

  // div_sel_d picks which divider a start goes to
  ffc_div #(
    .DVD_W (DIVIDEND_W),
    .DVS_W (8)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start && cmd.div_sel_d),
    .dividend (NUM),
    .divisor  (p_q),
    .done     (d_done),
    .quotient (d_quo)
  );

  ffc_cdiv #(
    .DVD_W   (DIVIDEND_W),
    .DIVISOR (SCREEN_W)
  ) u_cdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start && !cmd.div_sel_d),
    .dividend (prod_mag[DIVIDEND_W-1:0]),
    .done     (s_done),
    .quotient (s_quo)
  );

  // result fields from either the live item or the one latched at row setup
  assign p_src   = cmd.emit_latched ? p_q : clamp_p(row_offset);
  assign col_src = cmd.emit_latched ? col_q : column;
  assign pe      = ROW_W'(p_src);
  assign floor_w = ROW_W'(HALF) + pe;
  assign ceil_w  = ROW_W'(HALF) - pe - ROW_W'(1);

  always_comb begin
    res_next.out_column  = col_src;
    res_next.floor_row   = floor_w[8:0];
    res_next.ceil_row    = ceil_w[7:0];
    res_next.cell_x      = cell_of(world_x);
    res_next.cell_y      = cell_of(world_y);
    res_next.texel_x     = texel_of(world_x, TW_S, TW_M);
    res_next.texel_y     = texel_of(world_y, TH_S, TH_M);
    res_next.last_in_row = COL_W'(col_src) == COL_W'(SCREEN_W - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_distance <= '0;
      step_x       <= '0;
      step_y       <= '0;
      world_x      <= '0;
      world_y      <= '0;
    end else begin
      if (cmd.cap_d)
        row_distance <= (d_quo > DIVIDEND_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                            : signed'(d_quo[31:0]);
      if (cmd.cap_step_x) step_x <= sat32(67'(step_sh));
      if (cmd.cap_step_y) step_y <= sat32(67'(step_sh));
      if (cmd.cap_world_x) world_x <= sat32(67'(cfg.cam_pos_x) + 67'(prod_sh));
      if (cmd.cap_world_y) world_y <= sat32(67'(cfg.cam_pos_y) + 67'(prod_sh));
      if (cmd.emit_live || cmd.emit_latched) begin
        world_x <= sat32(67'(world_x) + 67'(step_x));
        world_y <= sat32(67'(world_y) + 67'(step_y));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      p_q   <= clamp_p(row_offset);
      col_q <= column;
    end
    if (cmd.mul_en) prod_q <= mul_a * mul_b;
    if (cmd.emit_live || cmd.emit_latched) res <= res_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ffc_ctrl.sv =====
// Controller: sequences row setup on the datapath and runs the input and
// output handshakes. Uses ffc_pkg command/status types.
`default_nettype none

module ffc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire ffc_pkg::dp_sts_t sts,
  output ffc_pkg::dp_cmd_t      cmd
);
  import ffc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_D,
    S_DIV_D,
    S_MUL_SX,
    S_DIV_SX,
    S_WAIT_SX,
    S_MUL_SY,
    S_DIV_SY,
    S_WAIT_SY,
    S_MUL_WX,
    S_CAP_WX,
    S_CAP_WY,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;
  logic   emit;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign emit     = cmd.emit_live || cmd.emit_latched;

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MSEL_PLANE_X;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (sts.col_zero) begin
            cmd.latch_item = 1'b1;
            state_next     = S_START_D;
          end else begin
            cmd.emit_live = 1'b1;
          end
        end
      end
      S_START_D: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_d = 1'b1;
        state_next    = S_DIV_D;
      end
      S_DIV_D: begin
        cmd.div_sel_d = 1'b1;
        if (sts.div_done) begin
          cmd.cap_d  = 1'b1;
          state_next = S_MUL_SX;
        end
      end
      S_MUL_SX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_PLANE_X;
        state_next  = S_DIV_SX;
      end
      S_DIV_SX: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT_SX;
      end
      S_WAIT_SX: begin
        if (sts.div_done) begin
          cmd.cap_step_x = 1'b1;
          state_next     = S_MUL_SY;
        end
      end
      S_MUL_SY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_PLANE_Y;
        state_next  = S_DIV_SY;
      end
      S_DIV_SY: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT_SY;
      end
      S_WAIT_SY: begin
        if (sts.div_done) begin
          cmd.cap_step_y = 1'b1;
          state_next     = S_MUL_WX;
        end
      end
      S_MUL_WX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_DIFF_X;
        state_next  = S_CAP_WX;
      end
      S_CAP_WX: begin
        // product for y loads on the same edge the x position is taken
        cmd.cap_world_x = 1'b1;
        cmd.mul_en      = 1'b1;
        cmd.mul_sel     = MSEL_DIFF_Y;
        state_next      = S_CAP_WY;
      end
      S_CAP_WY: begin
        cmd.cap_world_y = 1'b1;
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit_latched = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/floor_ceiling_texel_caster_core.sv =====
// Floor/ceiling texel caster: pixel items in on "pixel", one texel result
// per item out on "result", camera registers on an APB-style port.
//
// Each pixel beat carries a row offset below the horizon (clamped to
// 1..SCREEN_H/2) and a column. A beat with column 0 starts a row setup: the
// row distance is found by a bit-serial divider, then each of the two
// per-column steps takes one multiply and a division by the screen width
// (reciprocal multiply, 16 bits at a time), and the start position takes
// one multiply per axis. A column-0 item spends most of its setup in the
// distance division. Any other column produces its result in the output
// register in the cycle after acceptance, one pixel per cycle while the
// receiver keeps taking results.
// Results are held in the output register until taken; a new pixel beat is
// taken in the same cycle the held result drains, and none while the
// receiver stalls a full output register or during row setup.
// Reset (rst, synchronous) loads the camera register defaults, clears the
// distance, steps and world position to zero and empties the output.
// Registers: byte address 4*i; pready is always high.
`default_nettype none

module floor_ceiling_texel_caster_core #(
  parameter int SCREEN_W  = 640,
  parameter int SCREEN_H  = 480,
  parameter int TEXTURE_W = 64,
  parameter int TEXTURE_H = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ffc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ffc_pkg::DATA_W-1:0]  pwdata,
  output logic      [ffc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  ffc_pixel_if.sink                        pixel,
  ffc_result_if.source                     result
);
  import ffc_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;
  res_t    res;
  logic    wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cam_pos_x   <= RST_CAM_POS_X;
      cfg.cam_pos_y   <= RST_CAM_POS_Y;
      cfg.view_dir_x  <= RST_VIEW_DIR_X;
      cfg.view_dir_y  <= RST_VIEW_DIR_Y;
      cfg.cam_plane_x <= RST_CAM_PLANE_X;
      cfg.cam_plane_y <= RST_CAM_PLANE_Y;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CAM_POS_X:   cfg.cam_pos_x   <= signed'(pwdata);
        REG_CAM_POS_Y:   cfg.cam_pos_y   <= signed'(pwdata);
        REG_VIEW_DIR_X:  cfg.view_dir_x  <= signed'(pwdata);
        REG_VIEW_DIR_Y:  cfg.view_dir_y  <= signed'(pwdata);
        REG_CAM_PLANE_X: cfg.cam_plane_x <= signed'(pwdata);
        REG_CAM_PLANE_Y: cfg.cam_plane_y <= signed'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CAM_POS_X:   prdata = cfg.cam_pos_x;
      REG_CAM_POS_Y:   prdata = cfg.cam_pos_y;
      REG_VIEW_DIR_X:  prdata = cfg.view_dir_x;
      REG_VIEW_DIR_Y:  prdata = cfg.view_dir_y;
      REG_CAM_PLANE_X: prdata = cfg.cam_plane_x;
      REG_CAM_PLANE_Y: prdata = cfg.cam_plane_y;
      default:         prdata = '0;
    endcase
  end

  ffc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffc_datapath #(
    .SCREEN_W  (SCREEN_W),
    .SCREEN_H  (SCREEN_H),
    .TEXTURE_W (TEXTURE_W),
    .TEXTURE_H (TEXTURE_H),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .row_offset (pixel.row_offset),
    .column     (pixel.column),
    .res        (res)
  );

  assign result.out_column  = res.out_column;
  assign result.floor_row   = res.floor_row;
  assign result.ceil_row    = res.ceil_row;
  assign result.cell_x      = res.cell_x;
  assign result.cell_y      = res.cell_y;
  assign result.texel_x     = res.texel_x;
  assign result.texel_y     = res.texel_y;
  assign result.last_in_row = res.last_in_row;

endmodule

`default_nettype wire
